// ===== rtl/esv_pkg.sv =====
// Shared constants, types and register indexes of the ElGamal sign/verify core.
// No dependencies; every other file except esv_cell refers to it by scoped names.
package esv_pkg;

  localparam int MOD_BITS = 31;
  localparam int MOD_CW   = $clog2(MOD_BITS);

  localparam logic [MOD_BITS-1:0] RST_PRIME = MOD_BITS'(23);
  localparam logic [MOD_BITS-1:0] RST_GEN   = MOD_BITS'(5);
  localparam logic [MOD_BITS-1:0] RST_PRIV  = MOD_BITS'(6);

  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_PRIME = 2'd0;
  localparam logic [1:0] REG_GEN   = 2'd1;
  localparam logic [1:0] REG_PRIV  = 2'd2;

  localparam logic REQ_SIGN   = 1'b0;
  localparam logic REQ_VERIFY = 1'b1;

  // One request to the exponent unit: a^b mod m, or a*b mod m with a/m quotient
  typedef struct packed {
    logic                pow;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
    logic [MOD_BITS-1:0] m;
  } pm_op_t;

endpackage

// ===== rtl/esv_if.sv =====
// Handshake channels of the ElGamal core: request channel and result channel.
// Depends on esv_pkg for the field width.
interface esv_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [esv_pkg::MOD_BITS-1:0] message;
  logic [esv_pkg::MOD_BITS-1:0] nonce;
  logic [esv_pkg::MOD_BITS-1:0] sig_r_in;
  logic [esv_pkg::MOD_BITS-1:0] sig_s_in;
  modport source (output valid, req_type, message, nonce, sig_r_in, sig_s_in, input ready);
  modport sink   (input valid, req_type, message, nonce, sig_r_in, sig_s_in, output ready);
endinterface

interface esv_res_if;
  logic                         valid;
  logic                         ready;
  logic [esv_pkg::MOD_BITS-1:0] public_key;
  logic [esv_pkg::MOD_BITS-1:0] sig_r_out;
  logic [esv_pkg::MOD_BITS-1:0] sig_s_out;
  logic                         valid_res;
  logic                         status;
  modport source (output valid, public_key, sig_r_out, sig_s_out, valid_res, status,
                  input ready);
  modport sink   (input valid, public_key, sig_r_out, sig_s_out, valid_res, status,
                  output ready);
endinterface

// ===== rtl/elgamal_sign_verify_core.sv =====
// ElGamal sign/verify engine: top level with APB registers and request sequencer.
// Depends on esv_pkg, esv_if (esv_req_if, esv_res_if), esv_powmod.
//
// Usage: program p, g and x through the APB port (byte addresses 0, 4, 8), then
// send requests on in_ch. req_type 0 signs message with nonce and returns
// public_key, sig_r_out, sig_s_out and status (1 when p is below three or the
// nonce has no inverse mod p-1). req_type 1 checks (sig_r_in, sig_s_in) against
// message and returns public_key and valid_res. One result leaves on out_ch for
// every request. All products and powers run on one bit-serial multiplier (a
// chain of one-bit cells). A sign request runs two exponentiations plus the
// extended Euclid loop (two products per step) and stops after the loop when the
// nonce has no inverse; a verify request runs four exponentiations and a product.
// A modulus below two goes straight to the result step. One request is in flight
// at a time; in_ch.ready is high only while the engine is idle. The result sits
// in an output register; while the receiver stalls it holds, and a finished
// request waits in its last step until the register is free. Reset loads
// p=23, g=5, x=6 and empties the engine and the output register.
module elgamal_sign_verify_core (
  input  logic                           clk,
  input  logic                           rst_n,
  esv_req_if.sink                        in_ch,
  esv_res_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [esv_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int W = esv_pkg::MOD_BITS;

  typedef enum logic [14:0] {
    TS_IDLE = 15'h0001,
    TS_Y    = 15'h0002,
    TS_KMOD = 15'h0004,
    TS_CHK  = 15'h0008,
    TS_DIV  = 15'h0010,
    TS_TM   = 15'h0020,
    TS_R    = 15'h0040,
    TS_XR   = 15'h0080,
    TS_MN   = 15'h0100,
    TS_S    = 15'h0200,
    TS_V1   = 15'h0400,
    TS_YR   = 15'h0800,
    TS_RS   = 15'h1000,
    TS_V2   = 15'h2000,
    TS_FIN  = 15'h4000
  } ts_state_t;

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic [W-1:0] m);
    sub_mod = (a >= b) ? (a - b) : (a + (m - b));
  endfunction

  // configuration registers
  logic [W-1:0] p_r, g_r, x_r;
  logic         cfg_wr;

  ts_state_t    st_r, st_nxt;
  logic         issued_r, issued_nxt;
  logic         kind_r, kind_nxt;
  logic [W-1:0] msg_r, msg_nxt, k_r, k_nxt, rin_r, rin_nxt, sin_r, sin_nxt;
  logic [W-1:0] n_r, n_nxt, y_r, y_nxt, sr_r, sr_nxt, ss_r, ss_nxt;
  logic         vres_r, vres_nxt, stat_r, stat_nxt;
  logic [W-1:0] r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0] tmp_r, tmp_nxt, q_r, q_nxt;

  logic         ov_r, ov_nxt;
  logic [W-1:0] o_y_r, o_y_nxt, o_r_r, o_r_nxt, o_s_r, o_s_nxt;
  logic         o_v_r, o_v_nxt, o_st_r, o_st_nxt;

  esv_pkg::pm_op_t pm_op;
  logic            pm_start, pm_done, op_state;
  logic [W-1:0]    pm_res, pm_quo;
  logic            in_fire;

  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == TS_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= esv_pkg::RST_PRIME;
      g_r <= esv_pkg::RST_GEN;
      x_r <= esv_pkg::RST_PRIV;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        esv_pkg::REG_PRIME: p_r <= pwdata[W-1:0];
        esv_pkg::REG_GEN:   g_r <= pwdata[W-1:0];
        esv_pkg::REG_PRIV:  x_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      esv_pkg::REG_PRIME: prdata = 32'(p_r);
      esv_pkg::REG_GEN:   prdata = 32'(g_r);
      esv_pkg::REG_PRIV:  prdata = 32'(x_r);
      default:            prdata = '0;
    endcase
  end

  // operand selection for the exponent unit
  always_comb begin
    op_state = 1'b1;
    pm_op    = '{pow: 1'b0, a: g_r, b: W'(1), m: n_r};
    unique case (st_r)
      TS_Y:    pm_op = '{pow: 1'b1, a: g_r,   b: x_r,   m: p_r};
      TS_KMOD: pm_op = '{pow: 1'b0, a: k_r,   b: W'(1), m: n_r};
      TS_DIV:  pm_op = '{pow: 1'b0, a: r0_r,  b: W'(1), m: r1_r};
      TS_TM:   pm_op = '{pow: 1'b0, a: q_r,   b: t1_r,  m: n_r};
      TS_R:    pm_op = '{pow: 1'b1, a: g_r,   b: k_r,   m: p_r};
      TS_XR:   pm_op = '{pow: 1'b0, a: x_r,   b: sr_r,  m: n_r};
      TS_MN:   pm_op = '{pow: 1'b0, a: msg_r, b: W'(1), m: n_r};
      TS_S:    pm_op = '{pow: 1'b0, a: t0_r,  b: r1_r,  m: n_r};
      TS_V1:   pm_op = '{pow: 1'b1, a: g_r,   b: msg_r, m: p_r};
      TS_YR:   pm_op = '{pow: 1'b1, a: y_r,   b: rin_r, m: p_r};
      TS_RS:   pm_op = '{pow: 1'b1, a: rin_r, b: sin_r, m: p_r};
      TS_V2:   pm_op = '{pow: 1'b0, a: r0_r,  b: r1_r,  m: p_r};
      default: op_state = 1'b0;
    endcase
  end

  assign pm_start = op_state && !issued_r;

  esv_powmod u_pow (
    .clk   (clk),
    .rst_n (rst_n),
    .start (pm_start),
    .op    (pm_op),
    .done  (pm_done),
    .res   (pm_res),
    .quo   (pm_quo)
  );

  always_comb begin
    st_nxt     = st_r;
    issued_nxt = issued_r;
    kind_nxt   = kind_r;
    msg_nxt    = msg_r;
    k_nxt      = k_r;
    rin_nxt    = rin_r;
    sin_nxt    = sin_r;
    n_nxt      = n_r;
    y_nxt      = y_r;
    sr_nxt     = sr_r;
    ss_nxt     = ss_r;
    vres_nxt   = vres_r;
    stat_nxt   = stat_r;
    r0_nxt     = r0_r;
    r1_nxt     = r1_r;
    t0_nxt     = t0_r;
    t1_nxt     = t1_r;
    tmp_nxt    = tmp_r;
    q_nxt      = q_r;
    ov_nxt     = ov_r && !out_ch.ready;
    o_y_nxt    = o_y_r;
    o_r_nxt    = o_r_r;
    o_s_nxt    = o_s_r;
    o_v_nxt    = o_v_r;
    o_st_nxt   = o_st_r;

    if (pm_start) begin
      issued_nxt = 1'b1;
    end
    if (pm_done) begin
      issued_nxt = 1'b0;
    end

    unique case (st_r)
      TS_IDLE: begin
        if (in_fire) begin
          kind_nxt = in_ch.req_type;
          msg_nxt  = in_ch.message;
          k_nxt    = in_ch.nonce;
          rin_nxt  = in_ch.sig_r_in;
          sin_nxt  = in_ch.sig_s_in;
          n_nxt    = p_r - W'(1);
          y_nxt    = '0;
          sr_nxt   = '0;
          ss_nxt   = '0;
          vres_nxt = 1'b0;
          stat_nxt = 1'b0;
          if (p_r >= W'(2)) begin
            st_nxt = TS_Y;
          end else begin
            stat_nxt = (in_ch.req_type == esv_pkg::REQ_SIGN);
            st_nxt   = TS_FIN;
          end
        end
      end
      TS_Y: begin
        if (pm_done) begin
          y_nxt = pm_res;
          if (kind_r == esv_pkg::REQ_VERIFY) begin
            st_nxt = TS_V1;
          end else if (n_r >= W'(2)) begin
            r0_nxt = n_r;
            t0_nxt = '0;
            t1_nxt = W'(1);
            st_nxt = TS_KMOD;
          end else begin
            stat_nxt = 1'b1;
            st_nxt   = TS_FIN;
          end
        end
      end
      TS_KMOD: begin
        if (pm_done) begin
          r1_nxt = pm_res;
          st_nxt = TS_CHK;
        end
      end
      TS_CHK: begin
        if (r1_r == '0) begin
          if (r0_r == W'(1)) begin
            st_nxt = TS_R;
          end else begin
            stat_nxt = 1'b1;
            st_nxt   = TS_FIN;
          end
        end else begin
          st_nxt = TS_DIV;
        end
      end
      TS_DIV: begin
        if (pm_done) begin
          q_nxt   = pm_quo;
          tmp_nxt = pm_res;
          st_nxt  = TS_TM;
        end
      end
      TS_TM: begin
        if (pm_done) begin
          t1_nxt = sub_mod(t0_r, pm_res, n_r);
          t0_nxt = t1_r;
          r0_nxt = r1_r;
          r1_nxt = tmp_r;
          st_nxt = TS_CHK;
        end
      end
      TS_R: begin
        if (pm_done) begin
          sr_nxt = pm_res;
          st_nxt = TS_XR;
        end
      end
      TS_XR: begin
        if (pm_done) begin
          tmp_nxt = pm_res;
          st_nxt  = TS_MN;
        end
      end
      TS_MN: begin
        if (pm_done) begin
          r1_nxt = sub_mod(pm_res, tmp_r, n_r);
          st_nxt = TS_S;
        end
      end
      TS_S: begin
        if (pm_done) begin
          ss_nxt = pm_res;
          st_nxt = TS_FIN;
        end
      end
      TS_V1: begin
        if (pm_done) begin
          tmp_nxt = pm_res;
          st_nxt  = TS_YR;
        end
      end
      TS_YR: begin
        if (pm_done) begin
          r0_nxt = pm_res;
          st_nxt = TS_RS;
        end
      end
      TS_RS: begin
        if (pm_done) begin
          r1_nxt = pm_res;
          st_nxt = TS_V2;
        end
      end
      TS_V2: begin
        if (pm_done) begin
          vres_nxt = (pm_res == tmp_r);
          st_nxt   = TS_FIN;
        end
      end
      TS_FIN: begin
        // hold until the output register is free
        if (!ov_r) begin
          ov_nxt   = 1'b1;
          o_y_nxt  = y_r;
          o_r_nxt  = sr_r;
          o_s_nxt  = ss_r;
          o_v_nxt  = vres_r;
          o_st_nxt = stat_r;
          st_nxt   = TS_IDLE;
        end
      end
      default: st_nxt = TS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= TS_IDLE;
      issued_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      issued_r <= issued_nxt;
      ov_r     <= ov_nxt;
    end
    kind_r <= kind_nxt;
    msg_r  <= msg_nxt;
    k_r    <= k_nxt;
    rin_r  <= rin_nxt;
    sin_r  <= sin_nxt;
    n_r    <= n_nxt;
    y_r    <= y_nxt;
    sr_r   <= sr_nxt;
    ss_r   <= ss_nxt;
    vres_r <= vres_nxt;
    stat_r <= stat_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    tmp_r  <= tmp_nxt;
    q_r    <= q_nxt;
    o_y_r  <= o_y_nxt;
    o_r_r  <= o_r_nxt;
    o_s_r  <= o_s_nxt;
    o_v_r  <= o_v_nxt;
    o_st_r <= o_st_nxt;
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.public_key = o_y_r;
  assign out_ch.sig_r_out  = o_r_r;
  assign out_ch.sig_s_out  = o_s_r;
  assign out_ch.valid_res  = o_v_r;
  assign out_ch.status     = o_st_r;

endmodule

// ===== rtl/esv_cell.sv =====
// One bit cell of the operand chain: loads in parallel or takes its neighbour's bit.
// No dependencies.
module esv_cell (
  input  logic clk,
  input  logic load,
  input  logic load_bit,
  input  logic shift,
  input  logic shift_in,
  output logic bit_q
);

  logic bit_r;

  always_ff @(posedge clk) begin
    if (load) begin
      bit_r <= load_bit;
    end else if (shift) begin
      bit_r <= shift_in;
    end
  end

  assign bit_q = bit_r;

endmodule

// ===== rtl/esv_mulmod.sv =====
// Bit-serial modular multiplier over a chain of esv_cell: reduces a mod m (giving
// a/m as quotient), then forms a*b mod m MSB first. Depends on esv_pkg, esv_cell.
module esv_mulmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [esv_pkg::MOD_BITS-1:0] a,
  input  logic [esv_pkg::MOD_BITS-1:0] b,
  input  logic [esv_pkg::MOD_BITS-1:0] m,
  output logic                         done,
  output logic [esv_pkg::MOD_BITS-1:0] res,
  output logic [esv_pkg::MOD_BITS-1:0] quo
);

  localparam int W  = esv_pkg::MOD_BITS;
  localparam int CW = esv_pkg::MOD_CW;

  typedef enum logic [2:0] {
    MM_IDLE = 3'b001,
    MM_RED  = 3'b010,
    MM_MUL  = 3'b100
  } mm_state_t;

  mm_state_t      state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [W-1:0]   acc_r, acc_nxt;
  logic [W-1:0]   ared_r, ared_nxt;
  logic [W-1:0]   b_r, b_nxt;
  logic [W-1:0]   m_r, m_nxt;
  logic [W-1:0]   quo_r, quo_nxt;
  logic           done_r, done_nxt;

  logic [W-1:0]   chain;
  logic           top_bit;
  logic           last;
  logic           ch_load, ch_shift, ch_in;
  logic [W-1:0]   ch_load_val;

  logic [W:0]     red_t, red_sub, dbl, dbl_sub, sum, sum_sub, mw;
  logic           red_ge;
  logic [W-1:0]   red_val, dbl_val, sum_val;

  assign top_bit = chain[W-1];
  assign last    = (cnt_r == CW'(W - 1));
  assign mw      = {1'b0, m_r};

  // Horner step: 2*acc + bit, one conditional subtract
  assign red_t   = {acc_r, top_bit};
  assign red_sub = red_t - mw;
  assign red_ge  = (red_t >= mw);
  assign red_val = red_ge ? red_sub[W-1:0] : red_t[W-1:0];

  // Double, then add the reduced multiplicand when the bit is set
  assign dbl     = {acc_r, 1'b0};
  assign dbl_sub = dbl - mw;
  assign dbl_val = (dbl >= mw) ? dbl_sub[W-1:0] : dbl[W-1:0];
  assign sum     = {1'b0, dbl_val} + {1'b0, (top_bit ? ared_r : {W{1'b0}})};
  assign sum_sub = sum - mw;
  assign sum_val = (sum >= mw) ? sum_sub[W-1:0] : sum[W-1:0];

  assign ch_load     = (start && (state_r == MM_IDLE)) || ((state_r == MM_RED) && last);
  assign ch_load_val = (state_r == MM_IDLE) ? a : b_r;
  assign ch_shift    = (state_r == MM_RED) || (state_r == MM_MUL);
  assign ch_in       = (state_r == MM_RED) ? red_ge : 1'b0;

  for (genvar i = 0; i < W; i++) begin : g_chain
    esv_cell u_cell (
      .clk      (clk),
      .load     (ch_load),
      .load_bit (ch_load_val[i]),
      .shift    (ch_shift),
      .shift_in ((i == 0) ? ch_in : chain[(i == 0) ? 0 : i - 1]),
      .bit_q    (chain[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    ared_nxt  = ared_r;
    b_nxt     = b_r;
    m_nxt     = m_r;
    quo_nxt   = quo_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      MM_IDLE: begin
        if (start) begin
          b_nxt     = b;
          m_nxt     = m;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = MM_RED;
        end
      end
      MM_RED: begin
        acc_nxt = red_val;
        cnt_nxt = cnt_r + CW'(1);
        if (last) begin
          ared_nxt  = red_val;
          quo_nxt   = {chain[W-2:0], red_ge};
          acc_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = MM_MUL;
        end
      end
      MM_MUL: begin
        acc_nxt = sum_val;
        cnt_nxt = cnt_r + CW'(1);
        if (last) begin
          done_nxt  = 1'b1;
          state_nxt = MM_IDLE;
        end
      end
      default: state_nxt = MM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    ared_r <= ared_nxt;
    b_r    <= b_nxt;
    m_r    <= m_nxt;
    quo_r  <= quo_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/esv_powmod.sv =====
// Square-and-multiply exponent unit around esv_mulmod; also passes single products.
// Depends on esv_pkg, esv_mulmod.
module esv_powmod (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  esv_pkg::pm_op_t              op,
  output logic                         done,
  output logic [esv_pkg::MOD_BITS-1:0] res,
  output logic [esv_pkg::MOD_BITS-1:0] quo
);

  localparam int W  = esv_pkg::MOD_BITS;
  localparam int CW = esv_pkg::MOD_CW;

  typedef enum logic [3:0] {
    PM_IDLE = 4'b0001,
    PM_SQ   = 4'b0010,
    PM_MU   = 4'b0100,
    PM_ML   = 4'b1000
  } pm_state_t;

  pm_state_t     state_r, state_nxt;
  logic          go_r, go_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic [W-1:0]  base_r, base_nxt;
  logic [W-1:0]  e_r, e_nxt;
  logic [W-1:0]  m_r, m_nxt;

  logic [W-1:0]  mm_a, mm_b, mm_res;
  logic          mm_done;

  always_comb begin
    mm_a = base_r;
    mm_b = e_r;
    unique case (state_r)
      PM_SQ: begin
        mm_a = acc_r;
        mm_b = acc_r;
      end
      PM_MU: begin
        mm_a = base_r;
        mm_b = acc_r;
      end
      default: begin
        mm_a = base_r;
        mm_b = e_r;
      end
    endcase
  end

  esv_mulmod u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a     (mm_a),
    .b     (mm_b),
    .m     (m_r),
    .done  (mm_done),
    .res   (mm_res),
    .quo   (quo)
  );

  always_comb begin
    state_nxt = state_r;
    go_nxt    = 1'b0;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    e_nxt     = e_r;
    m_nxt     = m_r;
    unique case (state_r)
      PM_IDLE: begin
        if (start) begin
          base_nxt  = op.a;
          e_nxt     = op.b;
          m_nxt     = op.m;
          acc_nxt   = W'(1);
          cnt_nxt   = '0;
          go_nxt    = 1'b1;
          state_nxt = op.pow ? PM_SQ : PM_ML;
        end
      end
      PM_SQ, PM_MU: begin
        if (mm_done) begin
          acc_nxt = mm_res;
          if ((state_r == PM_SQ) && e_r[W-1]) begin
            go_nxt    = 1'b1;
            state_nxt = PM_MU;
          end else if (cnt_r == CW'(W - 1)) begin
            done_nxt  = 1'b1;
            state_nxt = PM_IDLE;
          end else begin
            // advance to the next exponent bit
            cnt_nxt   = cnt_r + CW'(1);
            e_nxt     = {e_r[W-2:0], 1'b0};
            go_nxt    = 1'b1;
            state_nxt = PM_SQ;
          end
        end
      end
      PM_ML: begin
        if (mm_done) begin
          acc_nxt   = mm_res;
          done_nxt  = 1'b1;
          state_nxt = PM_IDLE;
        end
      end
      default: state_nxt = PM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PM_IDLE;
      go_r    <= 1'b0;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
    end
    acc_r  <= acc_nxt;
    base_r <= base_nxt;
    e_r    <= e_nxt;
    m_r    <= m_nxt;
  end

  assign done = done_r;
  assign res  = acc_r;

endmodule
